// ===== hdl/pbin_pkg.sv =====
`timescale 1ns / 1ps

package pbin_pkg;

  // Field widths of the ports.
  localparam int PIX_W     = 16;
  localparam int BIN_W     = 5;
  localparam int SIZE_W    = 13;
  localparam int CFG_IDX_W = 2;

  localparam logic [PIX_W-1:0] PIX_MAX = 16'hFFFF;

  // Frame height is bounded independently of the line store depth.
  localparam int HEIGHT_LIMIT = 4096;

  localparam int DEF_MAX_WIDTH = 4096;
  localparam int DEF_MAX_BIN   = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BIN_X        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_Y        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd3;

  localparam logic [BIN_W-1:0]  BIN_RESET  = 5'd1;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;

  function automatic logic [PIX_W-1:0] sat_add(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
    logic [PIX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[PIX_W] ? PIX_MAX : s[PIX_W-1:0];
  endfunction

endpackage

// ===== hdl/pbin_line_store.sv =====
`timescale 1ns / 1ps

module pbin_line_store #(
  parameter int DEPTH = pbin_pkg::DEF_MAX_WIDTH
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [$clog2(DEPTH)-1:0]      wr_addr,
  input  logic [pbin_pkg::PIX_W-1:0]    wr_data,
  input  logic                          rd_en,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr,
  output logic [pbin_pkg::PIX_W-1:0]    rd_data
);

  logic [pbin_pkg::PIX_W-1:0] mem [DEPTH];

  // Read returns the old contents when the same entry is written in the same cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/pixel_binning_saturating.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Signals                                                   Beat
// pixel    in   pixel_valid, pixel_ready, pixel                           one source pixel
// binned   out  binned_valid, binned_ready, binned_pixel, end_of_line,
//               end_of_frame                                              one binned pixel
// cfg      in   cfg_valid, cfg_ready, cfg_index, cfg_data                 one register write
//
// One source pixel is taken every cycle while pixel_ready is high. A binned pixel passes
// the finish stage, then the output register, once its bin's last pixel is taken; the line store read is registered.
// Reset sets bin factors to 1 and frame size to 4096x4096 and clears all counters;
// the line store holds no reset value and is not swept.
// A two-entry output queue absorbs stalls; pixel_ready drops only while the queue is
// full and a finished sum is waiting to enter it.

module pixel_binning_saturating #(
  parameter int MAX_WIDTH = pbin_pkg::DEF_MAX_WIDTH,
  parameter int MAX_BIN   = pbin_pkg::DEF_MAX_BIN
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            pixel_valid,
  output logic                            pixel_ready,
  input  logic [pbin_pkg::PIX_W-1:0]      pixel,
  output logic                            binned_valid,
  input  logic                            binned_ready,
  output logic [pbin_pkg::PIX_W-1:0]      binned_pixel,
  output logic                            end_of_line,
  output logic                            end_of_frame,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pbin_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pbin_pkg::SIZE_W-1:0]     cfg_data
);

  localparam int PIX_W = pbin_pkg::PIX_W;
  localparam int BXW   = $clog2(MAX_BIN + 1);        // clamped bin factor
  localparam int PW    = $clog2(MAX_BIN);            // bin phase counters
  localparam int WW    = $clog2(MAX_WIDTH + 1);      // clamped width, output column
  localparam int SCW   = $clog2(MAX_WIDTH);          // source column
  localparam int AW    = $clog2(MAX_WIDTH);          // line store address
  localparam int HTW   = $clog2(pbin_pkg::HEIGHT_LIMIT + 1);
  localparam int SRW   = $clog2(pbin_pkg::HEIGHT_LIMIT);
  localparam int CPW   = WW + 1 + BXW;
  localparam int RPW   = HTW + 1 + BXW;

  // Configuration registers
  logic [pbin_pkg::BIN_W-1:0]  bin_x;
  logic [pbin_pkg::BIN_W-1:0]  bin_y;
  logic [pbin_pkg::SIZE_W-1:0] image_width;
  logic [pbin_pkg::SIZE_W-1:0] image_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_x        <= pbin_pkg::BIN_RESET;
      bin_y        <= pbin_pkg::BIN_RESET;
      image_width  <= pbin_pkg::SIZE_RESET;
      image_height <= pbin_pkg::SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pbin_pkg::REG_BIN_X:        bin_x        <= cfg_data[pbin_pkg::BIN_W-1:0];
        pbin_pkg::REG_BIN_Y:        bin_y        <= cfg_data[pbin_pkg::BIN_W-1:0];
        pbin_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        pbin_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective settings: zero acts as one, oversized values clamp.
  logic [BXW-1:0] bx;
  logic [BXW-1:0] by;
  logic [WW-1:0]  w;
  logic [HTW-1:0] h;

  always_comb begin
    if (bin_x == '0) bx = BXW'(1);
    else if (int'(bin_x) > MAX_BIN) bx = BXW'(MAX_BIN);
    else bx = BXW'(bin_x);

    if (bin_y == '0) by = BXW'(1);
    else if (int'(bin_y) > MAX_BIN) by = BXW'(MAX_BIN);
    else by = BXW'(bin_y);

    if (image_width == '0) w = WW'(1);
    else if (int'(image_width) > MAX_WIDTH) w = WW'(MAX_WIDTH);
    else w = WW'(image_width);

    if (image_height == '0) h = HTW'(1);
    else if (int'(image_height) > pbin_pkg::HEIGHT_LIMIT) h = HTW'(pbin_pkg::HEIGHT_LIMIT);
    else h = HTW'(image_height);
  end

  // Position counters
  logic [PIX_W-1:0] row_acc,  row_acc_next;
  logic [SCW-1:0]   src_col,  src_col_next;
  logic [SRW-1:0]   src_row,  src_row_next;
  logic [PW-1:0]    col_phase, col_phase_next;
  logic [PW-1:0]    row_phase, row_phase_next;
  logic [WW-1:0]    out_col,  out_col_next;
  logic [HTW-1:0]   out_row,  out_row_next;

  // Output column c is inside the frame when (c+1)*bx <= w, which is c < w/bx
  // without a divider. The same product plus bx tells whether c is the last one.
  logic [CPW-1:0] col_prod;
  logic [RPW-1:0] row_prod;
  logic           col_in, col_last, row_in, row_last, active;
  logic           col_done, row_done, line_wrap, frame_wrap;
  logic [PIX_W-1:0] acc_in;

  assign col_prod   = (CPW'(out_col) + CPW'(1)) * CPW'(bx);
  assign row_prod   = (RPW'(out_row) + RPW'(1)) * RPW'(by);
  assign col_in     = col_prod <= CPW'(w);
  assign col_last   = (col_prod + CPW'(bx)) > CPW'(w);
  assign row_in     = row_prod <= RPW'(h);
  assign row_last   = (row_prod + RPW'(by)) > RPW'(h);
  assign active     = col_in && row_in;
  assign col_done   = ((BXW + 1)'(col_phase) + (BXW + 1)'(1)) >= (BXW + 1)'(bx);
  assign row_done   = ((BXW + 1)'(row_phase) + (BXW + 1)'(1)) >= (BXW + 1)'(by);
  assign line_wrap  = ((SCW + 1)'(src_col) + (SCW + 1)'(1)) >= (SCW + 1)'(w);
  assign frame_wrap = ((SRW + 1)'(src_row) + (SRW + 1)'(1)) >= (SRW + 1)'(h);
  assign acc_in     = pbin_pkg::sat_add((col_phase == '0) ? '0 : row_acc, pixel);

  logic accept;
  assign accept = pixel_valid && pixel_ready;

  always_comb begin
    row_acc_next   = row_acc;
    src_col_next   = src_col;
    src_row_next   = src_row;
    col_phase_next = col_phase;
    row_phase_next = row_phase;
    out_col_next   = out_col;
    out_row_next   = out_row;
    if (accept) begin
      if (active) begin
        if (col_done) begin
          col_phase_next = '0;
          out_col_next   = out_col + WW'(1);
          row_acc_next   = '0;
        end else begin
          col_phase_next = col_phase + PW'(1);
          row_acc_next   = acc_in;
        end
      end
      if (line_wrap) begin
        src_col_next   = '0;
        col_phase_next = '0;
        out_col_next   = '0;
        row_acc_next   = '0;
        if (frame_wrap) begin
          src_row_next   = '0;
          row_phase_next = '0;
          out_row_next   = '0;
        end else begin
          src_row_next = src_row + SRW'(1);
          if (row_in) begin
            if (row_done) begin
              row_phase_next = '0;
              out_row_next   = out_row + HTW'(1);
            end else begin
              row_phase_next = row_phase + PW'(1);
            end
          end
        end
      end else begin
        src_col_next = src_col + SCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_acc   <= '0;
      src_col   <= '0;
      src_row   <= '0;
      col_phase <= '0;
      row_phase <= '0;
      out_col   <= '0;
      out_row   <= '0;
    end else begin
      row_acc   <= row_acc_next;
      src_col   <= src_col_next;
      src_row   <= src_row_next;
      col_phase <= col_phase_next;
      row_phase <= row_phase_next;
      out_col   <= out_col_next;
      out_row   <= out_row_next;
    end
  end

  // Finish stage: holds one completed column bin while the line store is read.
  logic             a_valid;
  logic             a_emit;
  logic             a_eol;
  logic             a_eof;
  logic             a_use_prev;
  logic             a_fwd;
  logic [PIX_W-1:0] a_acc;
  logic [PIX_W-1:0] a_fwd_data;
  logic [AW-1:0]    a_addr;

  logic             skid_valid;
  logic             a_go;
  logic             wr_en;
  logic [AW-1:0]    rd_addr;
  logic [PIX_W-1:0] rd_data;
  logic [PIX_W-1:0] prev;
  logic [PIX_W-1:0] total;

  assign a_go        = a_valid && (!a_emit || !skid_valid);
  assign wr_en       = a_go && !a_emit;
  assign pixel_ready = !a_valid || a_go;
  assign rd_addr     = out_col[AW-1:0];
  assign prev        = a_use_prev ? (a_fwd ? a_fwd_data : rd_data) : '0;
  assign total       = pbin_pkg::sat_add(a_acc, prev);

  pbin_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (a_addr),
    .wr_data (total),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= active && col_done;
    end else if (a_go) begin
      a_valid <= 1'b0;
    end
  end

  // A write that lands in the same cycle as the read of its entry is forwarded,
  // since the store returns the old contents.
  always_ff @(posedge clk) begin
    if (accept) begin
      a_emit     <= row_done;
      a_eol      <= col_last;
      a_eof      <= col_last && row_last;
      a_use_prev <= row_phase != '0;
      a_fwd      <= wr_en && (a_addr == rd_addr);
      a_fwd_data <= total;
      a_acc      <= acc_in;
      a_addr     <= rd_addr;
    end
  end

  // Two-entry output queue: the output register and a skid register behind it.
  logic             push, pop;
  logic [PIX_W-1:0] skid_pixel;
  logic             skid_eol;
  logic             skid_eof;

  assign push = a_go && a_emit;
  assign pop  = binned_valid && binned_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      binned_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!binned_valid || pop) begin
        binned_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      binned_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        binned_pixel <= skid_pixel;
        end_of_line  <= skid_eol;
        end_of_frame <= skid_eof;
      end
    end else if (push) begin
      if (!binned_valid || pop) begin
        binned_pixel <= total;
        end_of_line  <= a_eol;
        end_of_frame <= a_eof;
      end else begin
        skid_pixel <= total;
        skid_eol   <= a_eol;
        skid_eof   <= a_eof;
      end
    end
  end

endmodule

// ===== hdl/pbin_checker.sv =====
`timescale 1ns / 1ps

module pbin_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            pixel_ready,
  input logic                            binned_valid,
  input logic                            binned_ready,
  input logic [pbin_pkg::PIX_W-1:0]      binned_pixel,
  input logic                            end_of_line,
  input logic                            end_of_frame
);

  // A stalled result beat keeps its value and its marks.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    binned_valid && !binned_ready |=> binned_valid && $stable(binned_pixel)
      && $stable(end_of_line) && $stable(end_of_frame))
    else $error("binned beat changed while stalled");

  // The last pixel of a frame is always the last pixel of its line.
  a_eof_eol: assert property (@(posedge clk) disable iff (rst)
    binned_valid && end_of_frame |-> end_of_line)
    else $error("end_of_frame without end_of_line");

  // Reset empties the output queue.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !binned_valid)
    else $error("binned_valid high after reset");

  // The input only backs up behind a waiting result beat.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !pixel_ready |-> binned_valid)
    else $error("pixel_ready low with no result waiting");

endmodule

bind pixel_binning_saturating pbin_checker u_pbin_checker (.*);
